FILE: sv/assert_macros.svh
// Shared concurrent assertion helpers; clk and arst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define BBA_ASSERT_NOW(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("bba check failed");

// Next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("bba check failed");

`endif

FILE: sv/bba_pkg.sv
package bba_pkg;

	localparam int TOTAL_UNITS = 1024;
	localparam int LG_TOTAL    = $clog2(TOTAL_UNITS);
	localparam int TREE_NODES  = 2 * TOTAL_UNITS - 1;
	localparam int NODE_BITS   = $clog2(TREE_NODES);
	localparam int OWNER_BITS  = 16;
	localparam int SIZE_BITS   = 11;
	localparam int UNIT_BITS   = LG_TOTAL;
	localparam int CNT_BITS    = LG_TOTAL + 1;
	localparam int IDX_BITS    = LG_TOTAL;
	localparam int LG_BITS     = $clog2(LG_TOTAL + 1);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_BADSIZE  = 2'd3
	} status_t;

	typedef struct packed {
		logic                  kind;
		logic [OWNER_BITS-1:0] owner_id;
		logic [SIZE_BITS-1:0]  request_size;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [UNIT_BITS-1:0] block_start;
		logic [UNIT_BITS-1:0] block_end;
	} rsp_t;

	typedef struct packed {
		logic                  owned;
		logic [OWNER_BITS-1:0] owner;
	} own_word_t;

	typedef struct packed {
		logic                 busy_we;
		logic                 busy_wdata;
		logic [NODE_BITS-1:0] busy_waddr;
		logic [NODE_BITS-1:0] busy_raddr;
		logic                 own_we;
		own_word_t            own_wdata;
		logic [NODE_BITS-1:0] own_waddr;
		logic [NODE_BITS-1:0] own_raddr;
	} mem_req_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SIZE,
		S_SCAN,
		S_DECIDE,
		S_ANC,
		S_SUB,
		S_MRD,
		S_MCHK,
		S_RESP
	} state_t;

endpackage

FILE: sv/bba_ram.sv
module bba_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/bba_seq.sv
module bba_seq import bba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_t      req,
	input  logic      busy_rdata,
	input  own_word_t own_rdata,
	output mem_req_t  mem,
	input  logic      rsp_free,
	output logic      rsp_load,
	output rsp_t      rsp_word
);

	state_t state_q, state_d;

	logic [NODE_BITS-1:0]  clr_q;
	logic                  kind_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [SIZE_BITS-1:0]  size_q;
	logic [SIZE_BITS-1:0]  bsize_q;
	logic [LG_BITS-1:0]    lg_q;
	status_t               status_q;
	logic [CNT_BITS-1:0]   iss_q;
	logic                  rv_s1;
	logic [IDX_BITS-1:0]   ri_s1;
	logic                  pair_busy_q;
	logic                  ff_found_q, pf_found_q, own_found_q;
	logic [IDX_BITS-1:0]   ff_q, pf_q, own_i_q, pick_i_q;
	logic [NODE_BITS-1:0]  p_q, idx_q;
	logic [NODE_BITS:0]    lo_q, hi_q;

	logic [CNT_BITS-1:0]   count;
	logic [NODE_BITS-1:0]  first, scan_addr, par, buddy, sel_node;
	logic [IDX_BITS-1:0]   last_i, sel_i;
	logic                  sel_found, bad_size, more_iss, row_end, sub_done;
	logic [NODE_BITS:0]    nlo, nhi;
	logic [UNIT_BITS-1:0]  start;

	assign count     = CNT_BITS'(TOTAL_UNITS) >> lg_q;
	assign first     = NODE_BITS'(count - CNT_BITS'(1));
	assign last_i    = IDX_BITS'(count - CNT_BITS'(1));
	assign scan_addr = first + NODE_BITS'(iss_q);
	assign more_iss  = (iss_q != count);
	assign par       = (p_q - NODE_BITS'(1)) >> 1;
	assign buddy     = p_q[0] ? p_q + NODE_BITS'(1) : p_q - NODE_BITS'(1);
	assign bad_size  = (req.request_size == '0) ||
		(req.request_size > SIZE_BITS'(TOTAL_UNITS));
	assign nlo       = {lo_q[NODE_BITS-1:0], 1'b1};
	assign nhi       = {hi_q[NODE_BITS-1:0], 1'b0} + (NODE_BITS+1)'(2);
	assign row_end   = (idx_q == hi_q[NODE_BITS-1:0]);
	assign sub_done  = row_end && (nlo >= (NODE_BITS+1)'(TREE_NODES));

	always_comb begin
		if (kind_q == KIND_FREE) begin
			sel_found = own_found_q;
			sel_i     = own_i_q;
		end else begin
			sel_found = pf_found_q || ff_found_q;
			sel_i     = pf_found_q ? pf_q : ff_q;
		end
	end
	assign sel_node = first + NODE_BITS'(sel_i);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == NODE_BITS'(TREE_NODES - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (req_valid) state_d = bad_size ? S_RESP : S_SIZE;
			end
			S_SIZE: if (bsize_q >= size_q) state_d = S_SCAN;
			S_SCAN: if (rv_s1 && ri_s1 == last_i) state_d = S_DECIDE;
			S_DECIDE: begin
				if (!sel_found) state_d = S_RESP;
				else if (kind_q == KIND_FREE || sel_node == '0) state_d = S_SUB;
				else state_d = S_ANC;
			end
			S_ANC: if (par == '0) state_d = S_SUB;
			S_SUB: begin
				if (sub_done) state_d = (kind_q == KIND_FREE) ? S_MRD : S_RESP;
			end
			S_MRD: state_d = (p_q == '0) ? S_RESP : S_MCHK;
			S_MCHK: state_d = busy_rdata ? S_RESP : S_MRD;
			S_RESP: if (rsp_free) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// memory requests and handshake
	always_comb begin
		mem            = '0;
		mem.busy_raddr = (state_q == S_MRD) ? buddy : scan_addr;
		mem.own_raddr  = scan_addr;
		case (state_q)
			S_CLEAR: begin
				mem.busy_we    = 1'b1;
				mem.busy_waddr = clr_q;
				mem.own_we     = 1'b1;
				mem.own_waddr  = clr_q;
			end
			S_DECIDE: begin
				mem.own_we          = sel_found;
				mem.own_waddr       = sel_node;
				mem.own_wdata.owned = (kind_q == KIND_ALLOC);
				mem.own_wdata.owner = owner_q;
			end
			S_ANC: begin
				mem.busy_we    = 1'b1;
				mem.busy_waddr = par;
				mem.busy_wdata = 1'b1;
			end
			S_SUB: begin
				mem.busy_we    = 1'b1;
				mem.busy_waddr = idx_q;
				mem.busy_wdata = (kind_q == KIND_ALLOC);
			end
			S_MCHK: begin
				mem.busy_we    = !busy_rdata;
				mem.busy_waddr = par;
			end
			default: begin
				mem.busy_we = 1'b0;
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_load  = (state_q == S_RESP) && rsp_free;
	assign start     = pick_i_q << lg_q;

	always_comb begin
		rsp_word        = '0;
		rsp_word.status = status_q;
		if (status_q == ST_OK) begin
			rsp_word.block_start = start;
			rsp_word.block_end   = start | UNIT_BITS'(bsize_q - SIZE_BITS'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			rv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= (state_q == S_SCAN) && more_iss;
			if (state_q == S_CLEAR) clr_q <= clr_q + NODE_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		ri_s1 <= IDX_BITS'(iss_q);
		case (state_q)
			S_IDLE: begin
				kind_q   <= req.kind;
				owner_q  <= req.owner_id;
				size_q   <= req.request_size;
				bsize_q  <= SIZE_BITS'(1);
				lg_q     <= '0;
				status_q <= bad_size ? ST_BADSIZE : ST_OK;
			end
			S_SIZE: begin
				if (bsize_q < size_q) begin
					bsize_q <= bsize_q << 1;
					lg_q    <= lg_q + LG_BITS'(1);
				end
				iss_q       <= '0;
				ff_found_q  <= 1'b0;
				pf_found_q  <= 1'b0;
				own_found_q <= 1'b0;
			end
			S_SCAN: begin
				if (more_iss) iss_q <= iss_q + CNT_BITS'(1);
				if (rv_s1) begin
					if (!busy_rdata && !ff_found_q) begin
						ff_found_q <= 1'b1;
						ff_q       <= ri_s1;
					end
					// even index is a left child; decide the pair on its right half
					if (!ri_s1[0]) begin
						pair_busy_q <= busy_rdata;
					end else if (!pf_found_q) begin
						if (!pair_busy_q && busy_rdata) begin
							pf_found_q <= 1'b1;
							pf_q       <= ri_s1 - IDX_BITS'(1);
						end else if (pair_busy_q && !busy_rdata) begin
							pf_found_q <= 1'b1;
							pf_q       <= ri_s1;
						end
					end
					if (own_rdata.owned && own_rdata.owner == owner_q && !own_found_q) begin
						own_found_q <= 1'b1;
						own_i_q     <= ri_s1;
					end
				end
			end
			S_DECIDE: begin
				pick_i_q <= sel_i;
				p_q      <= sel_node;
				idx_q    <= sel_node;
				lo_q     <= {1'b0, sel_node};
				hi_q     <= {1'b0, sel_node};
				if (!sel_found) status_q <= (kind_q == KIND_FREE) ? ST_NOTFOUND : ST_NOSPACE;
			end
			S_ANC: p_q <= par;
			S_SUB: begin
				if (row_end) begin
					lo_q  <= nlo;
					hi_q  <= nhi;
					idx_q <= nlo[NODE_BITS-1:0];
				end else begin
					idx_q <= idx_q + NODE_BITS'(1);
				end
			end
			S_MCHK: if (!busy_rdata) p_q <= par;
			default: begin
				pair_busy_q <= pair_busy_q;
			end
		endcase
	end

endmodule

FILE: sv/buddy_block_allocator_top.sv
// Buddy allocator over a 1024-unit space, one request word in, one response word out.
// req carries kind (allocate or free), owner_id and request_size; rsp carries status,
// block_start and block_end. Both channels use valid/ready.
// After reset the block sweeps every node of the busy and owner memories, one node a cycle,
// with req_ready low; it then takes requests.
// Requests are handled one at a time by a sequencer over two single-port-write RAMs
// with registered reads. An item runs a step that rounds the size up to a power of two,
// a scan of that block size's tree level, then on allocate busy writes to the ancestors,
// writes to every node of the subtree, and on free a merge pass that clears each parent
// while its buddy is free. Bad sizes skip straight to the response.
// The level scan and the subtree sweep take most of the time.
// The response sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, the next response holds inside the sequencer
// until the output register drains.
module buddy_block_allocator_top import bba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	`include "assert_macros.svh"

	mem_req_t                  mem;
	logic                      busy_rdata;
	logic [$bits(own_word_t)-1:0] own_rdata;
	logic                      rsp_free, rsp_load;
	rsp_t                      rsp_word;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;

	bba_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.busy_rdata (busy_rdata),
		.own_rdata  (own_word_t'(own_rdata)),
		.mem        (mem),
		.rsp_free   (rsp_free),
		.rsp_load   (rsp_load),
		.rsp_word   (rsp_word)
	);

	bba_ram #(.WIDTH(1), .DEPTH(TREE_NODES)) u_busy_ram (
		.clk   (clk),
		.we    (mem.busy_we),
		.waddr (mem.busy_waddr),
		.wdata (mem.busy_wdata),
		.raddr (mem.busy_raddr),
		.rdata (busy_rdata)
	);

	bba_ram #(.WIDTH($bits(own_word_t)), .DEPTH(TREE_NODES)) u_own_ram (
		.clk   (clk),
		.we    (mem.own_we),
		.waddr (mem.own_waddr),
		.wdata (mem.own_wdata),
		.raddr (mem.own_raddr),
		.rdata (own_rdata)
	);

	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= rsp_word;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BBA_ASSERT_NOW(a_idle_no_write, req_ready, !mem.busy_we && !mem.own_we)
	`BBA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
	`BBA_ASSERT_NOW(a_error_zero_range, rsp_valid && rsp.status != ST_OK,
		rsp.block_start == '0 && rsp.block_end == '0)

endmodule
